@@ sv/ss_pkg.sv @@
// ss_pkg: shared types, constants and the case-fold helper for the substring search block
// no dependencies; imported by every module of the block

package ss_pkg;

  // default sizes, handed to the top level parameters
  localparam int MAX_PATTERN_DEF = 16;
  localparam int MAX_TEXT_DEF    = 65536;

  // fixed field widths
  localparam int PATTERN_BYTES = 16;
  localparam int PATTERN_W     = 8 * PATTERN_BYTES;
  localparam int LEN_W         = 5;
  localparam int POS_W         = 16;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 2;

  // register map of the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2,
    REG_IGNORE_CASE    = 2'd3
  } cfg_reg_t;

  // input beat
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } item_t;

  // output beat
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_position;
  } result_t;

  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;
  localparam logic [7:0] ASCII_CASE_D  = 8'h20;

  // upper-case a..z when folding is on
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold);
    logic [7:0] r;
    r = b;
    if (fold && (b >= ASCII_LOWER_A) && (b <= ASCII_LOWER_Z)) begin
      r = b - ASCII_CASE_D;
    end
    return r;
  endfunction

endpackage

@@ sv/ss_window.sv @@
// ss_window: shift register holding the most recent text bytes, newest at index 0
// depends on ss_pkg

module ss_window #(
  parameter int MAX_PATTERN = ss_pkg::MAX_PATTERN_DEF
) (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] new_byte,
  output logic [7:0] window_next [MAX_PATTERN]
);
  import ss_pkg::*;

  logic [7:0] recent [MAX_PATTERN];

  // view of the window with the incoming byte already shifted in
  always_comb begin
    window_next[0] = new_byte;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      window_next[i] = recent[i-1];
    end
  end

  // window storage, payload only
  always_ff @(posedge clk) begin
    if (shift) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        recent[i] <= window_next[i];
      end
    end
  end

endmodule

@@ sv/ss_match.sv @@
// ss_match: parallel compare of the window against the pattern, strncmp style
// depends on ss_pkg; purely combinational

module ss_match #(
  parameter int MAX_PATTERN = ss_pkg::MAX_PATTERN_DEF,
  parameter int MAX_TEXT    = ss_pkg::MAX_TEXT_DEF,
  localparam int CAP        = MAX_TEXT + MAX_PATTERN,
  localparam int CW         = $clog2(CAP + 1)
) (
  input  logic [7:0]                  window [MAX_PATTERN],
  input  logic [CW-1:0]               count_next,
  input  logic [ss_pkg::PATTERN_W-1:0] pattern,
  input  logic [ss_pkg::LEN_W-1:0]    pattern_length,
  input  logic                        ignore_case,
  output ss_pkg::result_t             res
);
  import ss_pkg::*;

  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] tap [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq;
  logic [MAX_PATTERN-1:0] pz;
  logic [7:0] tb;
  logic [7:0] pb;
  logic run;
  logic win;
  logic enough;
  logic late;
  logic hit;
  logic [CW-1:0] pos;
  logic [PW-1:0] pos_ext;

  // clamp the length to the window depth
  assign len = (pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pattern_length;

  // per-byte compare; pattern byte j meets the byte len-1-j positions back
  always_comb begin
    tb = '0;
    pb = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      tap[j] = len - LEN_W'(j) - LEN_W'(1);
      tb     = fold_byte(window[tap[j][IW-1:0]], ignore_case);
      pb     = fold_byte(pattern[8*j +: 8], ignore_case);
      eq[j]  = (tb == pb);
      pz[j]  = (pb == 8'h00);
    end
  end

  // prefix match; a matched zero byte past the first ends the compare early
  always_comb begin
    run = 1'b1;
    win = 1'b0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (LEN_W'(j) < len) begin
        run = run & eq[j];
        if (run && ((LEN_W'(j) == len - LEN_W'(1)) || ((j >= 1) && pz[j]))) begin
          win = 1'b1;
        end
      end
    end
  end

  // start offset and range checks
  assign enough  = (count_next >= CW'(len));
  assign pos     = count_next - CW'(len);
  assign late    = (pos >= CW'(MAX_TEXT));
  assign hit     = (len == '0) || (enough && !late && win);
  assign pos_ext = PW'(pos);

  always_comb begin
    res.found          = hit;
    res.match_position = '0;
    if (hit && (len != '0)) begin
      res.match_position = pos_ext[POS_W-1:0];
    end
  end

endmodule

@@ sv/ss_result_q.sv @@
// ss_result_q: two-entry result queue between the compare stage and the output port
// depends on ss_pkg

module ss_result_q (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ss_pkg::result_t push_data,
  output logic            full,
  output logic            result_valid,
  input  logic            result_ready,
  output ss_pkg::result_t result
);
  import ss_pkg::*;

  logic [1:0] count;
  logic [1:0] count_next;
  result_t    slot0;
  result_t    slot1;
  logic       pop;

  assign pop          = result_valid && result_ready;
  assign result_valid = (count != 2'd0);
  assign full         = (count == 2'd2);
  assign result       = slot0;

  // occupancy
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // entry storage; head moves up on pop
  always_ff @(posedge clk) begin
    if (pop) begin
      slot0 <= slot1;
    end
    if (push) begin
      if ((count == 2'd0) || ((count == 2'd1) && pop)) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end
  end

endmodule

@@ sv/substring_search_top.sv @@
// substring_search_top: streaming bounded substring search, one text byte per beat
// depends on ss_pkg, ss_window, ss_match, ss_result_q
// a result beat enters the result queue in the cycle after the input beat that causes it
// throughput: one input beat per cycle while the result queue is not full; the window compare is a single parallel pass
// input stalls only while both entries of the result queue hold undelivered beats
// reset clears the configuration registers, byte counter, report flag and result queue

module substring_search_top #(
  parameter int MAX_PATTERN = ss_pkg::MAX_PATTERN_DEF,
  parameter int MAX_TEXT    = ss_pkg::MAX_TEXT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  ss_pkg::item_t                  item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output ss_pkg::result_t                result,
  input  logic                           cfg_we,
  input  logic [ss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ss_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ss_pkg::*;

  localparam int CAP = MAX_TEXT + MAX_PATTERN;
  localparam int CW  = $clog2(CAP + 1);

  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [LEN_W-1:0]      pattern_length;
  logic                  ignore_case;

  logic          accept;
  logic          full;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          reported;
  logic          push;
  result_t       hit_res;
  result_t       push_data;
  logic [7:0]    window_next [MAX_PATTERN];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      ignore_case    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        REG_IGNORE_CASE:    ignore_case    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign accept     = item_valid && item_ready;
  assign item_ready = !full;

  // saturating byte count including the incoming byte
  assign count_next = (count < CW'(CAP)) ? count + CW'(1) : count;

  ss_window #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_window (
    .clk        (clk),
    .shift      (accept),
    .new_byte   (item.text_byte),
    .window_next(window_next)
  );

  ss_match #(
    .MAX_PATTERN(MAX_PATTERN),
    .MAX_TEXT   (MAX_TEXT)
  ) u_match (
    .window        (window_next),
    .count_next    (count_next),
    .pattern       ({pattern_high, pattern_low}),
    .pattern_length(pattern_length),
    .ignore_case   (ignore_case),
    .res           (hit_res)
  );

  // one result per text: first hit, or not-found on the last byte
  assign push = accept && !reported && (hit_res.found || item.end_of_text);

  always_comb begin
    push_data = '0;
    if (hit_res.found) begin
      push_data = hit_res;
    end
  end

  // per-text tracking, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      reported <= 1'b0;
    end else if (accept) begin
      if (item.end_of_text) begin
        count    <= '0;
        reported <= 1'b0;
      end else begin
        count    <= count_next;
        reported <= reported || hit_res.found;
      end
    end
  end

  ss_result_q u_result_q (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_data   (push_data),
    .full        (full),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

@@ sv/ss_checker.sv @@
// ss_checker: port-level assertions for substring_search_top, attached by bind
// depends on ss_pkg and substring_search_top

module ss_checker (
  input logic            clk,
  input logic            rst,
  input logic            item_valid,
  input logic            item_ready,
  input logic            result_valid,
  input logic            result_ready,
  input ss_pkg::result_t result
);
  import ss_pkg::*;

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // a not-found beat carries position zero
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |-> result.match_position == '0)
    else $error("not-found beat with nonzero position");

  // nothing to deliver right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result beat offered after reset");

  // a new result only follows an accepted input beat
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_valid && item_ready))
    else $error("result beat without an input beat");

  // input stalls only while results are waiting
  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid)
    else $error("input stalled with no pending result");

endmodule

bind substring_search_top ss_checker u_ss_checker (.*);
